// ----- rtl/rrts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

    // Fixed field widths
    localparam int OP_W      = 3;
    localparam int SEM_IDX_W = 3;
    localparam int SEM_W     = 16;
    localparam int SLEEP_W   = 16;
    localparam int PERIOD_W  = 10;
    localparam int TICK_W    = 10;
    localparam int FIRE_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int RUN_W     = 3;
    localparam int DIV_CNT_W = 4;

    localparam logic [TICK_W-1:0]       TICK_WRAP = 10'd1000;
    localparam logic signed [SEM_W-1:0] SEM_MAX   = 16'sh7FFF;
    localparam logic signed [SEM_W-1:0] SEM_MIN   = 16'sh8000;

    typedef enum logic [OP_W-1:0] {
        OP_YIELD  = 3'd0,
        OP_TICK   = 3'd1,
        OP_SLEEP  = 3'd2,
        OP_WAIT   = 3'd3,
        OP_SIGNAL = 3'd4,
        OP_INIT   = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_RUN    = 2'd1,
        ST_NO_WAITER = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_YSCAN,
        S_SSCAN,
        S_DIV,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic do_tick;
        logic do_sleep;
        logic do_wait;
        logic do_signal;
        logic do_init;
        logic scan_init;
        logic scan_y;
        logic scan_s;
        logic div_step;
        logic set_no_run;
        logic set_no_waiter;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            sem_ok;
        logic            wait_neg;
        logic            sig_nonpos;
        logic            y_hit;
        logic            s_hit;
        logic            scan_last;
        logic            div_last;
    } t_sts;

endpackage

`default_nettype wire

// ----- rtl/rrts_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rrts_ctrl import rrts_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_busy,
    output logic      o_valid
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_sts.op)
                    OP_YIELD: begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_YSCAN;
                    end
                    OP_TICK: begin
                        o_cmd.do_tick = 1'b1;
                        n_state       = S_DIV;
                    end
                    OP_SLEEP: begin
                        o_cmd.do_sleep  = 1'b1;
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_YSCAN;
                    end
                    OP_WAIT: begin
                        n_state = S_DONE;
                        if (i_sts.sem_ok) begin
                            o_cmd.do_wait = 1'b1;
                            if (i_sts.wait_neg) begin
                                o_cmd.scan_init = 1'b1;
                                n_state         = S_YSCAN;
                            end
                        end
                    end
                    OP_SIGNAL: begin
                        n_state = S_DONE;
                        if (i_sts.sem_ok) begin
                            o_cmd.do_signal = 1'b1;
                            if (i_sts.sig_nonpos) begin
                                o_cmd.scan_init = 1'b1;
                                n_state         = S_SSCAN;
                            end
                        end
                    end
                    OP_INIT: begin
                        o_cmd.do_init = i_sts.sem_ok;
                        n_state       = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_YSCAN: begin
                o_cmd.scan_y = 1'b1;
                if (i_sts.y_hit) begin
                    n_state = S_DONE;
                end else if (i_sts.scan_last) begin
                    o_cmd.set_no_run = 1'b1;
                    n_state          = S_DONE;
                end
            end
            S_SSCAN: begin
                o_cmd.scan_s = 1'b1;
                if (i_sts.s_hit) begin
                    n_state = S_DONE;
                end else if (i_sts.scan_last) begin
                    o_cmd.set_no_waiter = 1'b1;
                    n_state             = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted item did not make the block busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_busy)
        else $error("block still busy after delivering result");

endmodule

`default_nettype wire

// ----- rtl/rrts_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rrts_dp import rrts_pkg::*; #(
    parameter int THREADS    = 6,
    parameter int SEMAPHORES = 8,
    parameter int EVENTS     = 2
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cmd                    i_cmd,
    output t_sts                         o_sts,
    input  wire logic [OP_W-1:0]         i_op,
    input  wire logic [SEM_IDX_W-1:0]    i_sem_index,
    input  wire logic [SLEEP_W-1:0]      i_sleep_time,
    input  wire logic signed [SEM_W-1:0] i_init_value,
    input  wire logic [PERIOD_W-1:0]     i_period_a,
    input  wire logic [PERIOD_W-1:0]     i_period_b,
    output logic [RUN_W-1:0]             o_running_thread,
    output logic [FIRE_W-1:0]            o_event_fire,
    output logic [STATUS_W-1:0]          o_status,
    output logic signed [SEM_W-1:0]      o_sem_value
);

    localparam int TW = $clog2(THREADS);
    localparam int SW = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;
    localparam logic [TW-1:0] LAST_T = TW'(THREADS - 1);

    // thread / semaphore state
    logic [TW-1:0]              r_run;
    logic [THREADS-1:0]         r_blocked;
    logic [SEM_IDX_W-1:0]       r_bon   [THREADS];
    logic [SLEEP_W-1:0]         r_sleep [THREADS];
    logic signed [SEM_W-1:0]    r_sem   [SEMAPHORES];
    logic [TICK_W-1:0]          r_tick;

    // item registers
    logic [OP_W-1:0]            r_op;
    logic [SEM_IDX_W-1:0]       r_si;
    logic [SLEEP_W-1:0]         r_st;
    logic signed [SEM_W-1:0]    r_iv;
    logic [FIRE_W-1:0]          r_fire;
    t_status                    r_status;

    // ring scan and remainder unit
    logic [TW-1:0]              r_ptr;
    logic [TW-1:0]              r_cnt;
    logic [TICK_W-1:0]          r_dvd;
    logic [PERIOD_W-1:0]        r_rem [2];
    logic [DIV_CNT_W-1:0]       r_bit;

    logic                       w_sem_ok;
    logic [SW-1:0]              w_sidx;
    logic signed [SEM_W-1:0]    w_sem_cur;
    logic signed [SEM_W-1:0]    w_sem_dec;
    logic signed [SEM_W-1:0]    w_sem_inc;
    logic [TW-1:0]              w_cand;
    logic                       w_y_hit;
    logic                       w_s_hit;
    logic [TICK_W-1:0]          w_tick_inc;
    logic [PERIOD_W-1:0]        w_period   [2];
    logic [PERIOD_W:0]          w_trial    [2];
    logic [PERIOD_W-1:0]        w_rem_next [2];
    logic [FIRE_W-1:0]          w_fire;

    assign w_sem_ok  = (int'(r_si) < SEMAPHORES);
    assign w_sidx    = SW'(r_si);
    assign w_sem_cur = w_sem_ok ? r_sem[w_sidx] : '0;
    assign w_sem_dec = (w_sem_cur == SEM_MIN) ? w_sem_cur : w_sem_cur - 16'sd1;
    assign w_sem_inc = (w_sem_cur == SEM_MAX) ? w_sem_cur : w_sem_cur + 16'sd1;

    assign w_cand  = (r_ptr == LAST_T) ? '0 : r_ptr + TW'(1);
    assign w_y_hit = !r_blocked[w_cand] && (r_sleep[w_cand] == '0);
    assign w_s_hit = r_blocked[w_cand] && (r_bon[w_cand] == r_si);

    assign w_tick_inc = r_tick + TICK_W'(1);

    assign w_period[0] = i_period_a;
    assign w_period[1] = i_period_b;

    // one restoring step per cycle; MSB of the dividend shifts in
    always_comb begin
        for (int e = 0; e < 2; e++) begin
            w_trial[e] = {r_rem[e], r_dvd[TICK_W-1]};
            if (w_trial[e] >= {1'b0, w_period[e]}) begin
                w_rem_next[e] = PERIOD_W'(w_trial[e] - {1'b0, w_period[e]});
            end else begin
                w_rem_next[e] = PERIOD_W'(w_trial[e]);
            end
            w_fire[e] = (e < EVENTS) && (w_period[e] != '0) && (w_rem_next[e] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= '0;
            r_blocked <= '0;
            r_tick    <= '0;
            r_op      <= OP_YIELD;
            r_fire    <= '0;
            r_status  <= ST_OK;
            for (int t = 0; t < THREADS; t++) begin
                r_bon[t]   <= '0;
                r_sleep[t] <= '0;
            end
            for (int s = 0; s < SEMAPHORES; s++) begin
                r_sem[s] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_op     <= i_op;
                r_fire   <= '0;
                r_status <= ST_OK;
            end
            if (i_cmd.do_tick) begin
                r_tick <= (w_tick_inc == TICK_WRAP) ? '0 : w_tick_inc;
                for (int t = 0; t < THREADS; t++) begin
                    if (r_sleep[t] != '0) begin
                        r_sleep[t] <= r_sleep[t] - SLEEP_W'(1);
                    end
                end
            end
            if (i_cmd.do_sleep) begin
                r_sleep[r_run] <= r_st;
            end
            if (i_cmd.do_wait) begin
                r_sem[w_sidx] <= w_sem_dec;
                if (w_sem_dec[SEM_W-1]) begin
                    r_blocked[r_run] <= 1'b1;
                    r_bon[r_run]     <= r_si;
                end
            end
            if (i_cmd.do_signal) begin
                r_sem[w_sidx] <= w_sem_inc;
            end
            if (i_cmd.do_init) begin
                r_sem[w_sidx] <= r_iv;
            end
            if (i_cmd.scan_y && w_y_hit) begin
                r_run <= w_cand;
            end
            if (i_cmd.scan_s && w_s_hit) begin
                r_blocked[w_cand] <= 1'b0;
                r_bon[w_cand]     <= '0;
            end
            if (i_cmd.set_no_run) begin
                r_status <= ST_NO_RUN;
            end
            if (i_cmd.set_no_waiter) begin
                r_status <= ST_NO_WAITER;
            end
            if (i_cmd.div_step && (r_bit == '0)) begin
                r_fire <= w_fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_si <= i_sem_index;
            r_st <= i_sleep_time;
            r_iv <= i_init_value;
        end
        if (i_cmd.scan_init) begin
            r_ptr <= r_run;
            r_cnt <= '0;
        end else if (i_cmd.scan_y || i_cmd.scan_s) begin
            r_ptr <= w_cand;
            r_cnt <= r_cnt + TW'(1);
        end
        if (i_cmd.do_tick) begin
            r_dvd    <= w_tick_inc;
            r_rem[0] <= '0;
            r_rem[1] <= '0;
            r_bit    <= DIV_CNT_W'(TICK_W - 1);
        end else if (i_cmd.div_step) begin
            r_dvd    <= {r_dvd[TICK_W-2:0], 1'b0};
            r_rem[0] <= w_rem_next[0];
            r_rem[1] <= w_rem_next[1];
            r_bit    <= r_bit - DIV_CNT_W'(1);
        end
    end

    assign o_sts.op         = r_op;
    assign o_sts.sem_ok     = w_sem_ok;
    assign o_sts.wait_neg   = w_sem_dec[SEM_W-1];
    assign o_sts.sig_nonpos = w_sem_inc[SEM_W-1] || (w_sem_inc == '0);
    assign o_sts.y_hit      = w_y_hit;
    assign o_sts.s_hit      = w_s_hit;
    assign o_sts.scan_last  = (r_cnt == LAST_T);
    assign o_sts.div_last   = (r_bit == '0);

    assign o_running_thread = RUN_W'(r_run);
    assign o_event_fire     = r_fire;
    assign o_status         = r_status;
    assign o_sem_value      = w_sem_cur;

    a_fire_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fire != '0) |-> (r_op == OP_TICK))
        else $error("event fired on a non-tick item");

    a_nowaiter_signal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status == ST_NO_WAITER) |-> (r_op == OP_SIGNAL))
        else $error("no-waiter status on a non-signal item");

    a_switch_runnable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan_y && w_y_hit) |=> (!r_blocked[r_run] && (r_sleep[r_run] == '0)))
        else $error("switched to a thread that cannot run");

endmodule

`default_nettype wire

// ----- rtl/round_robin_thread_scheduler.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel    Signals                                         Handshake
// --------   ---------------------------------------------   ------------------------------
// command    i_op, i_sem_index, i_sleep_time, i_init_value   taken when start && !busy
// result     o_running_thread, o_event_fire, o_status,       o_valid, one cycle, no stall
//            o_sem_value
// config     psel, penable, pwrite, paddr, pwdata, prdata    APB write on access phase,
//                                                            pready tied high
//
// From accept to o_valid: init, tick-free semaphore ops that do not scan and undefined
// ops go from the execute state straight to the done state; yield, sleep, blocking wait
// and waking signal add a thread scan of k ring slots (1..THREADS), one per cycle; tick
// adds the 10-step remainder unit that tests the event periods.
// busy drops the cycle after o_valid; the next item may start then.
// Synchronous active-low reset clears all thread and semaphore state, the tick count
// and the controller; both event periods come out of reset as 1.
// Results cannot be held off: o_valid lasts one cycle only; later items change the fields.

module round_robin_thread_scheduler import rrts_pkg::*; #(
    parameter int THREADS    = 6,
    parameter int SEMAPHORES = 8,
    parameter int EVENTS     = 2
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // command channel
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [OP_W-1:0]         i_op,
    input  wire logic [SEM_IDX_W-1:0]    i_sem_index,
    input  wire logic [SLEEP_W-1:0]      i_sleep_time,
    input  wire logic signed [SEM_W-1:0] i_init_value,
    // result channel
    output logic                         o_valid,
    output logic [RUN_W-1:0]             o_running_thread,
    output logic [FIRE_W-1:0]            o_event_fire,
    output logic [STATUS_W-1:0]          o_status,
    output logic signed [SEM_W-1:0]      o_sem_value,
    // config port
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [2:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    // register map: index i at byte address 4*i
    localparam logic REG_PERIOD_A = 1'b0;
    localparam logic REG_PERIOD_B = 1'b1;

    logic [PERIOD_W-1:0] r_period_a;
    logic [PERIOD_W-1:0] r_period_b;
    logic                w_cfg_wr;
    logic                w_reg_idx;

    t_cmd w_cmd;
    t_sts w_sts;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_a <= PERIOD_W'(1);
            r_period_b <= PERIOD_W'(1);
        end else if (w_cfg_wr) begin
            if (w_reg_idx == REG_PERIOD_B) begin
                r_period_b <= pwdata[PERIOD_W-1:0];
            end else begin
                r_period_a <= pwdata[PERIOD_W-1:0];
            end
        end
    end

    assign prdata = (w_reg_idx == REG_PERIOD_A) ? 32'(r_period_a) : 32'(r_period_b);

    // sequencer: one state per phase of an item
    rrts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    // thread ring, semaphores, tick counter and remainder unit
    rrts_dp #(
        .THREADS    (THREADS),
        .SEMAPHORES (SEMAPHORES),
        .EVENTS     (EVENTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_op             (i_op),
        .i_sem_index      (i_sem_index),
        .i_sleep_time     (i_sleep_time),
        .i_init_value     (i_init_value),
        .i_period_a       (r_period_a),
        .i_period_b       (r_period_b),
        .o_running_thread (o_running_thread),
        .o_event_fire     (o_event_fire),
        .o_status         (o_status),
        .o_sem_value      (o_sem_value)
    );

endmodule

`default_nettype wire
